// ===== rtl/epg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the epicycloid point generator.
// No dependencies; every other file imports this package.
package epg_pkg;

  localparam int IDX_W    = 17;
  localparam int STEP_W   = 18;
  localparam int PIX_W    = 12;
  localparam int DIM_W    = 13;
  localparam int RATIO_W  = 4;
  localparam int SUM_W    = RATIO_W + 1;
  localparam int T_W      = IDX_W + STEP_W;
  localparam int N_W      = T_W + SUM_W;
  localparam int ANG_W    = 19;
  localparam int Z_W      = 20;
  localparam int XY_W     = 34;
  localparam int TRIG_W   = 19;
  localparam int SCALE_W  = DIM_W - 2;
  localparam int AB_W     = SCALE_W + SUM_W;
  localparam int B_W      = SCALE_W + RATIO_W;
  localparam int PROD_W   = AB_W + TRIG_W + 1;

  localparam int RED_BITS   = 4;
  localparam int RED_STAGES = N_W / RED_BITS;

  localparam int TWO_PI_Q16      = 411775;
  localparam int PI_Q16          = 205887;
  localparam int HALF_PI_Q16     = 102944;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int CORDIC_STEPS    = 17;

  localparam int ATAN_Q16 [0:CORDIC_STEPS-1] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1
  };

  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_OUTER   = 3'd2;
  localparam logic [2:0] REG_ROLLING = 3'd3;
  localparam logic [2:0] REG_STEP    = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [RATIO_W-1:0] outer;
    logic [RATIO_W-1:0] rolling;
    logic [STEP_W-1:0]  step;
  } cfg_t;

  typedef struct packed {
    logic [AB_W-1:0] ab;
    logic [B_W-1:0]  b;
    logic            busy;
  } geom_t;

  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [N_W-1:0]   t;
    logic [SUM_W-1:0] rem;
    logic [ANG_W-1:0] accu;
    logic [ANG_W-1:0] acct;
  } red_t;

  // one bit of a modulo-2pi accumulation: acc = (2*acc + b) mod 2pi
  function automatic logic [ANG_W-1:0] mod_step(logic [ANG_W-1:0] a, logic b);
    logic [ANG_W:0] v;
    v = {a, b};
    if (v >= (ANG_W+1)'(TWO_PI_Q16)) v = v - (ANG_W+1)'(TWO_PI_Q16);
    return v[ANG_W-1:0];
  endfunction

endpackage

// ===== rtl/epicycloid_point_generator.sv =====
`timescale 1ns / 1ps
// Epicycloid point generator top level: index multiply, angle reduction, two
// CORDIC pipelines and the pixel stage. Depends on epg_pkg and all epg_ modules.
//
// One beat in, one pixel out. The pipeline takes a new step index every cycle
// while the output is not stalled; a stall on the output freezes every stage at
// once. The depth comes from the 40-bit angle reduction (ten stages of four bits)
// and the 17-iteration CORDIC. After reset and after each register write the radii
// are rederived by an 11-step serial divider, which finishes long before the first
// beat reaches the pixel stage.
module epicycloid_point_generator
  import epg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IDX_W-1:0]   in_step_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   out_x_pixel,
  output logic [PIX_W-1:0]   out_y_pixel,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t                     cfg;
  geom_t                    geom;
  logic                     en;
  logic [SUM_W-1:0]         sum;
  logic                     v1_r, v2_r;
  logic [T_W-1:0]           t1_r, t2_r;
  logic [N_W-1:0]           n2_r;
  logic                     red_vld;
  logic [ANG_W-1:0]         t_mod, u_mod;
  logic                     t_vld, u_vld;
  logic signed [TRIG_W-1:0] ct, st, cu, su;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign sum      = {1'b0, cfg.outer} + {1'b0, cfg.rolling};

  epg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .geom    (geom)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= T_W'(in_step_index) * T_W'(cfg.step);
      t2_r <= t1_r;
      n2_r <= {{(N_W-T_W){1'b0}}, t1_r} * {{(N_W-SUM_W){1'b0}}, sum};
    end
  end

  epg_reduce u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v2_r),
    .t       (t2_r),
    .n       (n2_r),
    .divisor (cfg.rolling),
    .out_vld (red_vld),
    .t_mod   (t_mod),
    .u_mod   (u_mod)
  );

  epg_cordic u_cordic_t (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (red_vld),
    .theta   (t_mod),
    .out_vld (t_vld),
    .cos_q   (ct),
    .sin_q   (st)
  );

  epg_cordic u_cordic_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (red_vld),
    .theta   (u_mod),
    .out_vld (u_vld),
    .cos_q   (cu),
    .sin_q   (su)
  );

  epg_combine u_combine (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (t_vld & u_vld),
    .ct      (ct),
    .st      (st),
    .cu      (cu),
    .su      (su),
    .cfg     (cfg),
    .geom    (geom),
    .out_vld (out_valid),
    .x_pix   (out_x_pixel),
    .y_pix   (out_y_pixel)
  );

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    red_vld |-> (t_mod < ANG_W'(TWO_PI_Q16)) && (u_mod < ANG_W'(TWO_PI_Q16)))
    else $error("reduced angle outside one turn");

  a_radii_ready: assert property (@(posedge clk) disable iff (!rst_n)
    t_vld |-> !geom.busy)
    else $error("radii still being derived when a beat reaches the pixel stage");

  a_cordic_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    t_vld == u_vld)
    else $error("CORDIC pipelines out of step");

  a_centre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (geom.b == '0) |->
      (out_x_pixel == cfg.width[DIM_W-1:1]) && (out_y_pixel == cfg.height[DIM_W-1:1]))
    else $error("degenerate radius did not return the centre");

endmodule

// ===== rtl/epg_cfg.sv =====
`timescale 1ns / 1ps
// APB register file and the bit-serial scale divider that derives both radii.
// Depends on epg_pkg.
module epg_cfg
  import epg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg,
  output geom_t       geom
);

  localparam int CNT_W = $clog2(SCALE_W + 1);

  logic [DIM_W-1:0]   width_r, height_r;
  logic [RATIO_W-1:0] outer_r, rolling_r;
  logic [STEP_W-1:0]  step_r;
  logic               start_r, lag_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   rem_r;
  logic [SCALE_W-1:0] quo_r;
  logic [AB_W-1:0]    ab_r;
  logic [B_W-1:0]     b_r;
  logic               wr;
  logic [SUM_W-1:0]   sum;
  logic [DIM_W-1:0]   m;
  logic [SUM_W:0]     trial;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sum    = {1'b0, outer_r} + {1'b0, rolling_r};
  assign m      = (height_r < width_r) ? height_r : width_r;
  assign trial  = {rem_r, quo_r[SCALE_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DIM_W'(640);
      height_r  <= DIM_W'(480);
      outer_r   <= RATIO_W'(3);
      rolling_r <= RATIO_W'(1);
      step_r    <= STEP_W'(32768);
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_WIDTH:   width_r   <= pwdata[DIM_W-1:0];
        REG_HEIGHT:  height_r  <= pwdata[DIM_W-1:0];
        REG_OUTER:   outer_r   <= pwdata[RATIO_W-1:0];
        REG_ROLLING: rolling_r <= pwdata[RATIO_W-1:0];
        REG_STEP:    step_r    <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WIDTH:   prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_HEIGHT:  prdata = {{(32-DIM_W){1'b0}}, height_r};
      REG_OUTER:   prdata = {{(32-RATIO_W){1'b0}}, outer_r};
      REG_ROLLING: prdata = {{(32-RATIO_W){1'b0}}, rolling_r};
      REG_STEP:    prdata = {{(32-STEP_W){1'b0}}, step_r};
      default:     prdata = 32'd0;
    endcase
  end

  // restart the scale division after reset and after every write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      cnt_r   <= '0;
      lag_r   <= 1'b0;
    end else begin
      lag_r <= (cnt_r != '0);
      if (wr) begin
        start_r <= 1'b1;
      end else if (start_r) begin
        start_r <= 1'b0;
        cnt_r   <= CNT_W'(SCALE_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      rem_r <= '0;
      quo_r <= m[DIM_W-1:2];
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, sum}) begin
        rem_r <= SUM_W'(trial - {1'b0, sum});
        quo_r <= {quo_r[SCALE_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[SUM_W-1:0];
        quo_r <= {quo_r[SCALE_W-2:0], 1'b0};
      end
    end
    ab_r <= AB_W'(quo_r * sum);
    b_r  <= B_W'(quo_r * rolling_r);
  end

  assign cfg.width   = width_r;
  assign cfg.height  = height_r;
  assign cfg.outer   = outer_r;
  assign cfg.rolling = rolling_r;
  assign cfg.step    = step_r;
  assign geom.ab     = ab_r;
  assign geom.b      = b_r;
  assign geom.busy   = start_r | (cnt_r != '0) | lag_r;

endmodule

// ===== rtl/epg_reduce.sv =====
`timescale 1ns / 1ps
// Pipelined reduction of both angles modulo 2pi, four bits per stage; the second
// angle is also divided by the rolling ratio on the way. Depends on epg_pkg.
module epg_reduce
  import epg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [T_W-1:0]     t,
  input  logic [N_W-1:0]     n,
  input  logic [RATIO_W-1:0] divisor,
  output logic               out_vld,
  output logic [ANG_W-1:0]   t_mod,
  output logic [ANG_W-1:0]   u_mod
);

  red_t pipe_r [1:RED_STAGES];
  logic vld_r  [1:RED_STAGES];
  red_t head;

  function automatic red_t red_stage(red_t s, logic [RATIO_W-1:0] d, int base);
    red_t         r;
    logic [SUM_W:0] rm;
    logic         q;
    r = s;
    for (int j = 0; j < RED_BITS; j++) begin
      rm = {r.rem, r.n[base-j]};
      q  = (rm >= (SUM_W+1)'(d));
      if (q) rm = rm - (SUM_W+1)'(d);
      r.rem  = rm[SUM_W-1:0];
      r.accu = mod_step(r.accu, q);
      r.acct = mod_step(r.acct, r.t[base-j]);
    end
    return r;
  endfunction

  assign head.n    = n;
  assign head.t    = {{(N_W-T_W){1'b0}}, t};
  assign head.rem  = '0;
  assign head.accu = '0;
  assign head.acct = '0;

  for (genvar k = 0; k < RED_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) vld_r[1] <= 1'b0;
        else if (en) vld_r[1] <= in_vld;
      end
      always_ff @(posedge clk) begin
        if (en) pipe_r[1] <= red_stage(head, divisor, N_W - 1);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (!rst_n) vld_r[k+1] <= 1'b0;
        else if (en) vld_r[k+1] <= vld_r[k];
      end
      always_ff @(posedge clk) begin
        if (en) pipe_r[k+1] <= red_stage(pipe_r[k], divisor, N_W - 1 - RED_BITS*k);
      end
    end
  end

  assign out_vld = vld_r[RED_STAGES];
  assign t_mod   = pipe_r[RED_STAGES].acct;
  assign u_mod   = pipe_r[RED_STAGES].accu;

endmodule

// ===== rtl/epg_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined rotation CORDIC: quadrant fold, one iteration per stage, then rounding
// to Q16 cosine and sine. Depends on epg_pkg.
module epg_cordic
  import epg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [ANG_W-1:0]         theta,
  output logic                     out_vld,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q
);

  localparam logic signed [Z_W-1:0] PI_Z      = Z_W'(PI_Q16);
  localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(HALF_PI_Q16);
  localparam logic signed [Z_W-1:0] TWO_PI_Z  = Z_W'(TWO_PI_Q16);

  logic signed [XY_W-1:0] x_r [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r [0:CORDIC_STEPS];
  logic                   neg_r [0:CORDIC_STEPS];
  logic                   vld_r [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_fold;
  logic                   neg_fold;
  logic signed [XY_W-1:0] x_rnd, y_rnd;
  logic signed [TRIG_W-1:0] cos_nxt, sin_nxt;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic                   out_vld_r;

  always_comb begin
    z_fold   = $signed({1'b0, theta});
    neg_fold = 1'b0;
    if (z_fold > PI_Z) z_fold = z_fold - TWO_PI_Z;
    if (z_fold > HALF_PI_Z) begin
      z_fold   = z_fold - PI_Z;
      neg_fold = 1'b1;
    end else if (z_fold < -HALF_PI_Z) begin
      z_fold   = z_fold + PI_Z;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= XY_W'(CORDIC_GAIN_Q30);
      y_r[0]   <= '0;
      z_r[0]   <= z_fold;
      neg_r[0] <= neg_fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else if (en) vld_r[i+1] <= vld_r[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - Z_W'(ATAN_Q16[i]);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + Z_W'(ATAN_Q16[i]);
        end
      end
    end
  end

  assign x_rnd   = (x_r[CORDIC_STEPS] + XY_W'(8192)) >>> 14;
  assign y_rnd   = (y_r[CORDIC_STEPS] + XY_W'(8192)) >>> 14;
  assign cos_nxt = neg_r[CORDIC_STEPS] ? -x_rnd[TRIG_W-1:0] : x_rnd[TRIG_W-1:0];
  assign sin_nxt = neg_r[CORDIC_STEPS] ? -y_rnd[TRIG_W-1:0] : y_rnd[TRIG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= vld_r[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign cos_q   = cos_r;
  assign sin_q   = sin_r;

endmodule

// ===== rtl/epg_combine.sv =====
`timescale 1ns / 1ps
// Radius products, truncating Q16 difference and centre offset; holds the output
// register of the block. Depends on epg_pkg.
module epg_combine
  import epg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic signed [TRIG_W-1:0] ct,
  input  logic signed [TRIG_W-1:0] st,
  input  logic signed [TRIG_W-1:0] cu,
  input  logic signed [TRIG_W-1:0] su,
  input  cfg_t                     cfg,
  input  geom_t                    geom,
  output logic                     out_vld,
  output logic [PIX_W-1:0]         x_pix,
  output logic [PIX_W-1:0]         y_pix
);

  logic signed [PROD_W-1:0] xa_r, xb_r, ya_r, yb_r;
  logic signed [PROD_W-1:0] ab_s, b_s;
  logic                     vld1_r, vld2_r;
  logic [PIX_W-1:0]         x_r, y_r, cx, cy, x_nxt, y_nxt;
  logic                     b_zero;

  function automatic logic [PIX_W-1:0] to_pix(logic signed [PROD_W:0] d,
                                              logic [PIX_W-1:0] c);
    logic signed [PROD_W:0] q;
    if (d < 0) q = (d + (PROD_W+1)'(65535)) >>> 16;
    else       q = d >>> 16;
    return q[PIX_W-1:0] + c;
  endfunction

  assign ab_s   = $signed({{(PROD_W-AB_W){1'b0}}, geom.ab});
  assign b_s    = $signed({{(PROD_W-B_W){1'b0}}, geom.b});
  assign cx     = cfg.width[DIM_W-1:1];
  assign cy     = cfg.height[DIM_W-1:1];
  assign b_zero = (geom.b == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r <= ab_s * PROD_W'(ct);
      xb_r <= b_s  * PROD_W'(cu);
      ya_r <= ab_s * PROD_W'(st);
      yb_r <= b_s  * PROD_W'(su);
    end
  end

  assign x_nxt = b_zero ? cx : to_pix((PROD_W+1)'(xa_r) - (PROD_W+1)'(xb_r), cx);
  assign y_nxt = b_zero ? cy : to_pix((PROD_W+1)'(ya_r) - (PROD_W+1)'(yb_r), cy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign out_vld = vld2_r;
  assign x_pix   = x_r;
  assign y_pix   = y_r;

endmodule

// ===== tb/epicycloid_point_generator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for epicycloid_point_generator: table-driven and random step
// indices over several window and ratio settings, scored against a CORDIC predictor.
// Depends on epg_pkg and the generator RTL.
module epicycloid_point_generator_tb;
  import epg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [RATIO_W-1:0] rolling;
    logic [IDX_W-1:0]   idx;
    bit                 known;
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
  } row_t;

  typedef struct {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [IDX_W-1:0]   in_step_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   out_x_pixel;
  logic [PIX_W-1:0]   out_y_pixel;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  longint mir_w, mir_h, mir_outer, mir_rolling, mir_step;
  pixel_t pending_pixels[$];
  int     mismatches = 0;
  int     beats_in = 0;
  int     beats_out = 0;
  int     cycles = 0;
  int     stall_hold = 0;
  bit     stall_calm = 1'b0;

  epicycloid_point_generator dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("epicycloid_point_generator test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_calm) begin
      stall_hold = 0;
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      stall_hold = $urandom_range(10, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(50, 300)) @(negedge clk);
      stall_calm = ~stall_calm;
    end
  end

  function automatic void cordic_sincos(input longint theta, output longint c,
                                        output longint s);
    longint z, x, y, dx, dy;
    bit     neg;
    z = theta;
    x = CORDIC_GAIN_Q30;
    y = 0;
    neg = 1'b0;
    if (z > PI_Q16) z -= TWO_PI_Q16;
    if (z > HALF_PI_Q16) begin
      z -= PI_Q16;
      neg = 1'b1;
    end else if (z < -HALF_PI_Q16) begin
      z += PI_Q16;
      neg = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q16[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q16[i];
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic pixel_t curve_pixel(input logic [IDX_W-1:0] idx);
    pixel_t p;
    longint m, sum, scale, ab, b, t, u, ct, st, cu, su, xv, yv;
    m = (mir_h < mir_w) ? mir_h : mir_w;
    sum = mir_outer + mir_rolling;
    scale = (sum != 0) ? ((m / 2) / 2) / sum : 0;
    ab = scale * sum;
    b = scale * mir_rolling;
    if (b == 0) begin
      p.x = PIX_W'(mir_w / 2);
      p.y = PIX_W'(mir_h / 2);
      return p;
    end
    t = longint'(idx) * mir_step;
    u = (ab * t) / b;
    cordic_sincos(t % TWO_PI_Q16, ct, st);
    cordic_sincos(u % TWO_PI_Q16, cu, su);
    xv = (ab * ct - b * cu) / 65536 + mir_w / 2;
    yv = (ab * st - b * su) / 65536 + mir_h / 2;
    p.x = PIX_W'(xv);
    p.y = PIX_W'(yv);
    return p;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_out <= beats_out + 1;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: x=%0d y=%0d", out_x_pixel, out_y_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (want.x !== out_x_pixel || want.y !== out_y_pixel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected (%0d,%0d) got (%0d,%0d)",
                     want.x, want.y, out_x_pixel, out_y_pixel);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] regno, input longint value);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {regno, 2'b00}; pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (regno)
      REG_WIDTH:   mir_w = value & 13'h1FFF;
      REG_HEIGHT:  mir_h = value & 13'h1FFF;
      REG_OUTER:   mir_outer = value & 4'hF;
      REG_ROLLING: mir_rolling = value & 4'hF;
      REG_STEP:    mir_step = value & 18'h3FFFF;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input longint w, input longint h, input longint o,
                               input longint r, input longint s);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_OUTER, o);
    write_reg(REG_ROLLING, r);
    write_reg(REG_STEP, s);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_index(input logic [IDX_W-1:0] idx, input bit no_gap);
    int g;
    g = no_gap ? 0 : pick_gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1'b1;
    in_step_index = idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(curve_pixel(idx));
    beats_in++;
    @(negedge clk);
  endtask

  row_t directed[$] = '{
    '{4'd1, 17'd0,      1'b0, 12'd0,   12'd0},
    '{4'd1, 17'd1,      1'b0, 12'd0,   12'd0},
    '{4'd1, 17'd2,      1'b0, 12'd0,   12'd0},
    '{4'd1, 17'd3,      1'b0, 12'd0,   12'd0},
    '{4'd1, 17'd7,      1'b0, 12'd0,   12'd0},
    '{4'd1, 17'h0FFFF,  1'b0, 12'd0,   12'd0},
    '{4'd1, 17'h10000,  1'b0, 12'd0,   12'd0},
    '{4'd1, 17'h15555,  1'b0, 12'd0,   12'd0},
    '{4'd1, 17'h0AAAA,  1'b0, 12'd0,   12'd0},
    '{4'd1, 17'h1FFFF,  1'b0, 12'd0,   12'd0},
    '{4'd0, 17'd0,      1'b1, 12'd320, 12'd240},
    '{4'd0, 17'h1FFFF,  1'b1, 12'd320, 12'd240},
    '{4'd0, 17'h0AAAA,  1'b1, 12'd320, 12'd240},
    '{4'd0, 17'h15555,  1'b1, 12'd320, 12'd240}
  };

  longint settings[10][5] = '{
    '{4096, 4096, 15, 15, 205887},
    '{4,    4,    1,  1,  1},
    '{8191, 8191, 15, 1,  262143},
    '{4096, 4,    1,  15, 65536},
    '{4,    4096, 3,  1,  32768},
    '{8191, 0,    2,  3,  1234},
    '{0,    0,    0,  0,  0},
    '{1024, 768,  4,  1,  3001},
    '{2000, 3000, 7,  2,  100000},
    '{640,  480,  3,  1,  32768}
  };

  initial begin
    logic [RATIO_W-1:0] cur_rolling;
    row_t      row;
    pixel_t    want;
    bit        calm;
    int        ph;
    logic [IDX_W-1:0] idx;
    mir_w = 640; mir_h = 480; mir_outer = 3; mir_rolling = 1; mir_step = 32768;
    cur_rolling = 4'd1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    repeat (SETTLE) @(negedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.rolling != cur_rolling) begin
        drain();
        write_reg(REG_ROLLING, longint'(row.rolling));
        repeat (SETTLE) @(negedge clk);
        cur_rolling = row.rolling;
      end
      want = curve_pixel(row.idx);
      if (row.known && (want.x != row.x || want.y != row.y)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: expected (%0d,%0d) predictor (%0d,%0d)",
                   i, row.x, row.y, want.x, want.y);
      end
      send_index(row.idx, 1'b0);
    end
    drain();

    for (ph = 0; ph < 12; ph++) begin
      if (ph < 10)
        apply_setting(settings[ph][0], settings[ph][1], settings[ph][2],
                      settings[ph][3], settings[ph][4]);
      else
        apply_setting(longint'($urandom_range(4, 4096)), longint'($urandom_range(4, 4096)),
                      longint'($urandom_range(1, 15)), longint'($urandom_range(1, 15)),
                      longint'($urandom_range(1, 205887)));
      calm = 1'b0;
      for (int k = 0; k < 92; k++) begin
        if (k % 30 == 0) calm = ~calm;
        if (ph == 4 && k == 46) drain();
        case ($urandom_range(0, 9))
          0: idx = 17'h1FFFF;
          1: idx = IDX_W'($urandom_range(0, 15));
          default: idx = IDX_W'($urandom_range(0, 131071));
        endcase
        send_index(idx, calm);
      end
      drain();
    end

    $display("covered %0d beats in, %0d beats out across %0d register settings",
             beats_in, beats_out, 13);
    $display("including zero ratios, minimum and maximum windows and angle steps");
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("epicycloid_point_generator test passed");
    else
      $display("epicycloid_point_generator test failed");
    $finish;
  end

endmodule
